[hdl/distance_vector_route_merge_macros.svh]
// ---------------------------------------------------------------------------
// distance_vector_route_merge assertion macros
// Clocked, reset-qualified property shorthands used by the port checker.
// ---------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_MERGE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_MERGE_MACROS_SVH

// same-cycle implication
`define DVRM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dvrm assertion failed");

// next-cycle implication
`define DVRM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dvrm assertion failed");

`endif

[hdl/dvrm_pkg.sv]
// ---------------------------------------------------------------------------
// dvrm_pkg
// Shared constants, status codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package dvrm_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int ID_BITS       = 16;
   localparam int FIELD_ID_BITS = 16;
   localparam int ID_W          = (ID_BITS < FIELD_ID_BITS) ? ID_BITS : FIELD_ID_BITS;
   localparam int DIST_BITS     = 8;
   localparam int ADDR_BITS     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int COUNT_BITS    = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_BITS    = 2 * ID_W + DIST_BITS;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_IMPROVED = 2'd1;
   localparam logic [1:0] ST_KEPT     = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic load_req;
      logic addr_step;
      logic resolve_local;
      logic resolve_hit;
      logic resolve_miss;
      logic rsp_load;
   } dvrm_cmd_type;

   typedef struct packed {
      logic own_hit;
      logic table_empty;
      logic entry_match;
      logic entry_last;
      logic rsp_free;
   } dvrm_sts_type;

endpackage

[hdl/dvrm_ram.sv]
// ---------------------------------------------------------------------------
// dvrm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dvrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dvrm_ctrl.sv]
// ---------------------------------------------------------------------------
// dvrm_ctrl
// Sequencer: accept, scan the table one entry per read/compare pair, resolve,
// then hand the result to the output register.
// ---------------------------------------------------------------------------
module dvrm_ctrl
   import dvrm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dvrm_sts_type sts,
   output dvrm_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            // read of the current entry is in flight
            if (sts.own_hit) begin
               cmd.resolve_local = 1'b1;
               state_in          = S_OUT;
            end else if (sts.table_empty) begin
               cmd.resolve_miss = 1'b1;
               state_in         = S_OUT;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.entry_match) begin
               cmd.resolve_hit = 1'b1;
               state_in        = S_OUT;
            end else if (sts.entry_last) begin
               cmd.resolve_miss = 1'b1;
               state_in         = S_OUT;
            end else begin
               cmd.addr_step = 1'b1;
               state_in      = S_READ;
            end
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/dvrm_datapath.sv]
// ---------------------------------------------------------------------------
// dvrm_datapath
// Request registers, scan address, fill count, route RAM and result registers.
// ---------------------------------------------------------------------------
module dvrm_datapath
   import dvrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic [15:0]          req_dest_id,
   input  logic [DIST_BITS-1:0] req_adv_distance,
   input  logic [15:0]          req_source_id,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_merge_status,
   output logic [15:0]          rsp_route_nexthop,
   output logic [DIST_BITS-1:0] rsp_route_distance,
   output logic                 rsp_route_local,
   input  dvrm_cmd_type         cmd,
   output dvrm_sts_type         sts
);

   logic [ID_W-1:0]       own_ff, own_in;
   logic [ID_W-1:0]       dest_ff, dest_in;
   logic [ID_W-1:0]       src_ff, src_in;
   logic [DIST_BITS-1:0]  cand_ff, cand_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [1:0]            res_status_ff, res_status_in;
   logic [ID_W-1:0]       res_hop_ff, res_hop_in;
   logic [DIST_BITS-1:0]  res_dist_ff, res_dist_in;
   logic                  res_local_ff, res_local_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]       rsp_hop_ff, rsp_hop_in;
   logic [DIST_BITS-1:0]  rsp_dist_ff, rsp_dist_in;
   logic                  rsp_local_ff, rsp_local_in;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [ENTRY_BITS-1:0] ram_wdata;
   logic [ENTRY_BITS-1:0] ram_rdata;

   logic [ID_W-1:0]       rd_dest;
   logic [ID_W-1:0]       rd_hop;
   logic [DIST_BITS-1:0]  rd_dist;
   logic                  table_full;

   dvrm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rd_dest    = ram_rdata[ENTRY_BITS-1 -: ID_W];
   assign rd_hop     = ram_rdata[DIST_BITS +: ID_W];
   assign rd_dist    = ram_rdata[DIST_BITS-1:0];
   assign table_full = (count_ff == COUNT_BITS'(TABLE_ENTRIES));

   assign sts.own_hit     = (dest_ff == own_ff);
   assign sts.table_empty = (count_ff == '0);
   assign sts.entry_match = (rd_dest == dest_ff);
   assign sts.entry_last  = ((COUNT_BITS'(addr_ff) + COUNT_BITS'(1)) == count_ff);
   assign sts.rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      own_in        = own_ff;
      dest_in       = dest_ff;
      src_in        = src_ff;
      cand_in       = cand_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_hop_in    = res_hop_ff;
      res_dist_in   = res_dist_ff;
      res_local_in  = res_local_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_local_in  = rsp_local_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = {dest_ff, src_ff, cand_ff};

      if (csr_wr_en) begin
         own_in = csr_wr_data[ID_W-1:0];
      end

      if (cmd.load_req) begin
         dest_in = req_dest_id[ID_W-1:0];
         src_in  = req_source_id[ID_W-1:0];
         cand_in = (req_adv_distance == DIST_MAX) ? DIST_MAX
                                                  : req_adv_distance + DIST_BITS'(1);
         addr_in = '0;
      end

      if (cmd.addr_step) begin
         addr_in = addr_ff + ADDR_BITS'(1);
      end

      if (cmd.resolve_local) begin
         res_status_in = ST_KEPT;
         res_hop_in    = {ID_W{1'b1}};
         res_dist_in   = '0;
         res_local_in  = 1'b1;
      end

      if (cmd.resolve_hit) begin
         res_local_in = 1'b0;
         if (cand_ff < rd_dist) begin
            ram_we        = 1'b1;
            ram_waddr     = addr_ff;
            res_status_in = ST_IMPROVED;
            res_hop_in    = src_ff;
            res_dist_in   = cand_ff;
         end else begin
            res_status_in = ST_KEPT;
            res_hop_in    = rd_hop;
            res_dist_in   = rd_dist;
         end
      end

      if (cmd.resolve_miss) begin
         res_local_in = 1'b0;
         if (table_full) begin
            res_status_in = ST_FULL;
            res_hop_in    = '0;
            res_dist_in   = '0;
         end else begin
            ram_we        = 1'b1;
            ram_waddr     = count_ff[ADDR_BITS-1:0];
            count_in      = count_ff + COUNT_BITS'(1);
            res_status_in = ST_INSERTED;
            res_hop_in    = src_ff;
            res_dist_in   = cand_ff;
         end
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_hop_in    = res_hop_ff;
         rsp_dist_in   = res_dist_ff;
         rsp_local_in  = res_local_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         own_ff       <= own_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff       <= dest_in;
      src_ff        <= src_in;
      cand_ff       <= cand_in;
      addr_ff       <= addr_in;
      res_status_ff <= res_status_in;
      res_hop_ff    <= res_hop_in;
      res_dist_ff   <= res_dist_in;
      res_local_ff  <= res_local_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_local_ff  <= rsp_local_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_merge_status   = rsp_status_ff;
   assign rsp_route_nexthop  = 16'(rsp_hop_ff);
   assign rsp_route_distance = rsp_dist_ff;
   assign rsp_route_local    = rsp_local_ff;

endmodule

[hdl/distance_vector_route_merge.sv]
// ---------------------------------------------------------------------------
// distance_vector_route_merge
// Merges advertised distance-vector routes into a route table held in RAM.
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake          payload
//   req       in          req_valid/ready    dest_id, adv_distance, source_id
//   rsp       out         rsp_valid/ready    merge_status, route_nexthop,
//                                            route_distance, route_local
//   csr       in          csr_wr_en          own_as_number (csr_wr_data)
//
// Sequence: a transaction to the own number or into an empty table goes from
//   the read state straight to the output state; otherwise the scan passes a
//   read and a compare state for each of m table entries read (hit position + 1,
//   or the fill count on a miss). The single RAM read port sets this.
// Reset: clears the fill count, the own number and the output valid; the
//   route RAM itself is not cleared, entries beyond the fill count are never read.
// Stalls: a result waits in the output register; the sequencer holds its
//   finished result until that register is free, then takes the next request.
//
module distance_vector_route_merge
   import dvrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_dest_id,
   input  logic [7:0]  req_adv_distance,
   input  logic [15:0] req_source_id,
   // response
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_merge_status,
   output logic [15:0] rsp_route_nexthop,
   output logic [7:0]  rsp_route_distance,
   output logic        rsp_route_local
);

   dvrm_cmd_type cmd;
   dvrm_sts_type sts;

   // sequencer: idle, read entry, compare entry, present result
   dvrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table RAM, fill count, request and result registers
   dvrm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_dest_id        (req_dest_id),
      .req_adv_distance   (req_adv_distance),
      .req_source_id      (req_source_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_merge_status   (rsp_merge_status),
      .rsp_route_nexthop  (rsp_route_nexthop),
      .rsp_route_distance (rsp_route_distance),
      .rsp_route_local    (rsp_route_local),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

[hdl/dvrm_checker.sv]
// ---------------------------------------------------------------------------
// dvrm_checker
// Port-level checks on the route merge block, bound to the top level.
// ---------------------------------------------------------------------------
`include "distance_vector_route_merge_macros.svh"

module dvrm_checker
   import dvrm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        csr_wr_en,
   input logic [15:0] csr_wr_data,
   input logic        req_valid,
   input logic        req_ready,
   input logic [15:0] req_dest_id,
   input logic [7:0]  req_adv_distance,
   input logic [15:0] req_source_id,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_merge_status,
   input logic [15:0] rsp_route_nexthop,
   input logic [7:0]  rsp_route_distance,
   input logic        rsp_route_local
);

   // one transaction in flight: ready drops after each accept
   `DVRM_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // a presented result is held until taken
   `DVRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // local route: kept, distance zero
   `DVRM_ASSERT_IMPL(a_local_route, rsp_valid && rsp_route_local, (rsp_merge_status == ST_KEPT) && (rsp_route_distance == 8'd0))

   // dropped transaction carries zeroed route fields
   `DVRM_ASSERT_IMPL(a_full_zero, rsp_valid && (rsp_merge_status == ST_FULL), (rsp_route_nexthop == 16'd0) && (rsp_route_distance == 8'd0) && !rsp_route_local)

endmodule

bind distance_vector_route_merge dvrm_checker u_dvrm_checker (.*);
